@@ design/frustum_box_cull_macros.svh @@
// ============================================================================
// frustum_box_cull assertion macros
// shared concurrent assertion forms for the frustum box cull checks
// ============================================================================
`ifndef FRUSTUM_BOX_CULL_MACROS_SVH
`define FRUSTUM_BOX_CULL_MACROS_SVH

// same-cycle implication
`define FBC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frustum_box_cull check failed");

// next-cycle implication
`define FBC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frustum_box_cull check failed");

`endif

@@ design/fbc_pkg.sv @@
// ============================================================================
// fbc_pkg
// types, widths and plane extraction shared by the frustum box cull block
// ============================================================================
package fbc_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int COMP_W      = VALUE_WIDTH + 1;
    localparam int PROD_W      = COMP_W + VALUE_WIDTH;
    localparam int TERM_W      = (PROD_W > COMP_W + FRAC_BITS) ? PROD_W : COMP_W + FRAC_BITS;
    localparam int SUM_W       = TERM_W + 2;
    localparam int NUM_PLANES  = 6;
    localparam int NUM_AXES    = 3;
    localparam int MAT_ROWS    = 4;
    localparam int MAT_DEPTH   = 16;
    localparam int IDX_W       = 4;
    localparam int S_TDATA_W   = 8 * ((IDX_W + 7 * VALUE_WIDTH + 7) / 8);
    localparam int S_TUSER_W   = 1;
    localparam int M_TDATA_W   = 8;

    typedef logic signed [VALUE_WIDTH-1:0] coord_t;
    typedef logic signed [COMP_W-1:0]      comp_t;
    typedef logic signed [PROD_W-1:0]      prod_t;
    typedef logic signed [SUM_W-1:0]       sum_t;
    typedef logic [VALUE_WIDTH-1:0]        elem_t;
    typedef logic [IDX_W-1:0]              idx_t;
    typedef elem_t [MAT_DEPTH-1:0]         matrix_t;

    typedef enum logic {
        FUNC_WRITE = 1'b0,
        FUNC_TEST  = 1'b1
    } func_t;

    typedef struct packed {
        coord_t hi;
        coord_t lo;
    } span_t;

    typedef span_t [NUM_AXES-1:0] box_t;

    typedef struct packed {
        comp_t                          w;
        logic [NUM_AXES-1:0][COMP_W-1:0] n;
    } plane_t;

    typedef plane_t [NUM_PLANES-1:0] plane_set_t;

    // left, right, bottom, top, near, far
    localparam logic [NUM_PLANES-1:0] PLANE_HAS_R3 = 6'b101111;
    localparam logic [NUM_PLANES-1:0] PLANE_NEG    = 6'b101010;
    localparam int PLANE_ROW [NUM_PLANES] = '{0, 0, 1, 1, 2, 2};

    // component c of plane p, c = 3 is the offset
    function automatic comp_t plane_comp(matrix_t m, int p, int c);
        idx_t  row_idx;
        idx_t  r3_idx;
        comp_t v;
        comp_t r3;
        row_idx = IDX_W'(c * MAT_ROWS + PLANE_ROW[p]);
        r3_idx  = IDX_W'(c * MAT_ROWS + MAT_ROWS - 1);
        v       = COMP_W'($signed(m[row_idx]));
        r3      = COMP_W'($signed(m[r3_idx]));
        if (PLANE_NEG[p])
        begin
            v = -v;
        end
        if (PLANE_HAS_R3[p])
        begin
            v = v + r3;
        end
        return v;
    endfunction

endpackage

@@ design/frustum_box_cull.sv @@
// ============================================================================
// frustum_box_cull
// view-frustum test of axis-aligned boxes against planes of a stored matrix
// ============================================================================
// a box beat passes box1_reg, the plane-test product registers and visible_reg before its result shows on m_tvalid
// throughput: one beat per cycle while m_tready does not stall the pipeline, matrix writes and box tests alike
// a write takes effect for any box accepted after it
// reset clears the matrix to zero and empties the pipeline
module frustum_box_cull (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // elem_index, elem_value, min_x, min_y, min_z, max_x, max_y, max_z
    input  logic [fbc_pkg::S_TDATA_W-1:0]   s_tdata,
    // func
    input  logic [fbc_pkg::S_TUSER_W-1:0]   s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // visible
    output logic [fbc_pkg::M_TDATA_W-1:0]   m_tdata
);
    import fbc_pkg::*;

    func_t      func;
    idx_t       elem_index;
    elem_t      elem_value;
    box_t       box_in;
    logic       accept;
    logic       wr_en;
    logic       en1;
    logic       en2;
    logic       en3;
    plane_set_t planes;
    logic [NUM_PLANES-1:0] outside;

    logic v1_reg;
    logic v2_reg;
    logic v3_reg;
    box_t box1_reg;
    logic visible_reg;

    assign func       = func_t'(s_tuser[0]);
    assign elem_index = s_tdata[IDX_W-1:0];
    assign elem_value = s_tdata[IDX_W +: VALUE_WIDTH];

    always_comb
    begin
        for (int a = 0; a < NUM_AXES; a++)
        begin
            box_in[a].lo = s_tdata[IDX_W + VALUE_WIDTH * (1 + a) +: VALUE_WIDTH];
            box_in[a].hi = s_tdata[IDX_W + VALUE_WIDTH * (4 + a) +: VALUE_WIDTH];
        end
    end

    // stage enables
    assign en3      = !v3_reg || m_tready;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign s_tready = en1;
    assign accept   = s_tvalid && s_tready;
    assign wr_en    = accept && (func == FUNC_WRITE);

    fbc_plane_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_idx   (elem_index),
        .wr_value (elem_value),
        .planes   (planes)
    );

    for (genvar p = 0; p < NUM_PLANES; p++)
    begin : g_plane
        fbc_plane_test u_test (
            .clk     (clk),
            .en      (en2),
            .plane   (planes[p]),
            .box     (box1_reg),
            .outside (outside[p])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= accept && (func == FUNC_TEST);
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            box1_reg <= box_in;
        end
        if (en3)
        begin
            visible_reg <= ~|outside;
        end
    end

    assign m_tvalid = v3_reg;
    assign m_tdata  = M_TDATA_W'(visible_reg);

endmodule

@@ design/fbc_plane_store.sv @@
// ============================================================================
// fbc_plane_store
// matrix element registers and the six extracted frustum planes
// ============================================================================
module fbc_plane_store (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  fbc_pkg::idx_t      wr_idx,
    input  fbc_pkg::elem_t     wr_value,
    output fbc_pkg::plane_set_t planes
);
    import fbc_pkg::*;

    matrix_t    matrix_reg;
    matrix_t    matrix_next;
    plane_set_t plane_reg;
    plane_set_t plane_next;

    always_comb
    begin
        matrix_next = matrix_reg;
        if (wr_en)
        begin
            matrix_next[wr_idx] = wr_value;
        end
        for (int p = 0; p < NUM_PLANES; p++)
        begin
            plane_next[p].w = plane_comp(matrix_next, p, MAT_ROWS - 1);
            for (int a = 0; a < NUM_AXES; a++)
            begin
                plane_next[p].n[a] = plane_comp(matrix_next, p, a);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            matrix_reg <= '0;
            plane_reg  <= '0;
        end
        else
        begin
            matrix_reg <= matrix_next;
            plane_reg  <= plane_next;
        end
    end

    assign planes = plane_reg;

endmodule

@@ design/fbc_plane_test.sv @@
// ============================================================================
// fbc_plane_test
// farthest-corner products for one plane and the sign of the plane distance
// ============================================================================
module fbc_plane_test (
    input  logic            clk,
    input  logic            en,
    input  fbc_pkg::plane_t plane,
    input  fbc_pkg::box_t   box,
    output logic            outside
);
    import fbc_pkg::*;

    prod_t prod_reg  [NUM_AXES];
    prod_t prod_next [NUM_AXES];
    comp_t w_reg;
    sum_t  sum;

    always_comb
    begin
        comp_t  n;
        coord_t lo;
        coord_t hi;
        coord_t big;
        coord_t sml;
        coord_t sel;
        prod_t  n_ext;
        prod_t  c_ext;
        for (int a = 0; a < NUM_AXES; a++)
        begin
            n     = $signed(plane.n[a]);
            lo    = box[a].lo;
            hi    = box[a].hi;
            big   = (hi > lo) ? hi : lo;
            sml   = (hi > lo) ? lo : hi;
            sel   = n[COMP_W-1] ? sml : big;
            n_ext = PROD_W'(n);
            c_ext = PROD_W'(sel);
            prod_next[a] = PROD_W'(n_ext * c_ext);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int a = 0; a < NUM_AXES; a++)
            begin
                prod_reg[a] <= prod_next[a];
            end
            w_reg <= plane.w;
        end
    end

    always_comb
    begin
        sum = SUM_W'(prod_reg[0]) + SUM_W'(prod_reg[1]) + SUM_W'(prod_reg[2])
            + (SUM_W'(w_reg) <<< FRAC_BITS);
    end

    assign outside = sum[SUM_W-1];

endmodule

@@ design/fbc_checker.sv @@
// ============================================================================
// fbc_checker
// port-level checks of the frustum box cull block, bound to the top level
// ============================================================================
`include "frustum_box_cull_macros.svh"

module fbc_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [fbc_pkg::S_TUSER_W-1:0] s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [fbc_pkg::M_TDATA_W-1:0] m_tdata
);
    import fbc_pkg::*;

    logic [2:0] pending_reg;
    logic [2:0] pending_next;
    logic       box_in;
    logic       res_out;

    // box beats in flight
    assign box_in  = s_tvalid && s_tready && (func_t'(s_tuser[0]) == FUNC_TEST);
    assign res_out = m_tvalid && m_tready;

    always_comb
    begin
        pending_next = pending_reg + 3'(box_in) - 3'(res_out);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    `FBC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `FBC_ASSERT_NOW(a_stall_only_when_full, !s_tready, m_tvalid && !m_tready)
    `FBC_ASSERT_NOW(a_result_has_box, m_tvalid, pending_reg != 3'd0)
    `FBC_ASSERT_NOW(a_depth_bound, s_tvalid || !s_tvalid, pending_reg <= 3'd3)
    `FBC_ASSERT_NOW(a_pad_zero, m_tvalid, m_tdata[M_TDATA_W-1:1] == '0)

endmodule

bind frustum_box_cull fbc_checker u_fbc_checker (.*);
